// ----- design/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// cons must hold at every clock edge at which ante holds
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- design/mbet_pkg.sv -----
// Shared types, constants and helpers for the escape-time core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mbet_pkg;

  localparam int INDEX_BITS = 12;
  localparam int FRAC_BITS  = 24;
  localparam int ITER_W     = 16;
  localparam int RAD_W      = 7;
  localparam int STEP_W     = 31;
  localparam int MAG_W      = 64 - 2 * FRAC_BITS;

  localparam int ROB_DEPTH  = 4;
  localparam int TAG_W      = $clog2(ROB_DEPTH);

  localparam int APB_AW     = 5;
  localparam int REG_IDX_W  = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ORIGIN_RE  = 3'd0,
    REG_ORIGIN_IM  = 3'd1,
    REG_PIXEL_STEP = 3'd2,
    REG_MAX_ITER   = 3'd3,
    REG_RADIUS_SQ  = 3'd4
  } mbet_reg_e;

  localparam logic signed [31:0]     RST_ORIGIN_RE = -32'sd40265318;
  localparam logic signed [31:0]     RST_ORIGIN_IM = -32'sd9227469;
  localparam logic [STEP_W-1:0]      RST_STEP      = 31'd37749;
  localparam logic [ITER_W-1:0]      RST_MAX_ITER  = 16'd256;
  localparam logic [RAD_W-1:0]       RST_RADIUS_SQ = 7'd100;

  localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [INDEX_BITS-1:0] pixel_col;
    logic [INDEX_BITS-1:0] pixel_row;
  } mbet_in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  iter_count;
    logic               inside_res;
    logic signed [31:0] escape_re;
    logic signed [31:0] escape_im;
  } mbet_out_t;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [STEP_W-1:0]  pixel_step;
    logic [ITER_W-1:0]  max_iter;
    logic [RAD_W-1:0]   escape_radius_sq;
  } mbet_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    mbet_out_t        res;
  } mbet_done_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > SAT_HI) begin
      return 32'sh7fff_ffff;
    end else if (v < SAT_LO) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

// ----- design/mandelbrot_escape_time_core.sv -----
// Top level of the escape-time core: registers, iteration ring, reorder buffer.
// Depends on mbet_pkg, mbet_cfg_regs, mbet_iter_ring, mbet_reorder.
//
//   channel  | signals                              | handshake
//   ---------+--------------------------------------+-------------------------------
//   pixel    | pixel_i (col, row)                   | taken when start & !busy
//   result   | result_o (count, inside, z)          | result_valid_o, one cycle only
//   config   | psel penable pwrite paddr pwdata ... | APB, pready tied high
//
// A pixel's result word follows a set-up pass that forms c, one pass per iteration and a
// final test pass, plus any wait behind older words: each iteration is one trip round the
// three-stage ring. Up to three pixels interleave in the ring and four may be outstanding;
// results leave in acceptance order. busy is high while a ring slot recirculates into the
// entry stage or the reorder buffer is full. No clearing pass after reset.
`timescale 1ns / 1ps

module mandelbrot_escape_time_core import mbet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mbet_in_t          pixel_i,
  output logic              result_valid_o,
  output mbet_out_t         result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  mbet_cfg_t        cfg;
  mbet_done_t       done;
  logic [TAG_W-1:0] tag;
  logic             slot_busy, rob_full, enter;

  assign busy  = slot_busy | rob_full;
  assign enter = start & !busy;

  mbet_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mbet_iter_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enter_i     (enter),
    .pixel_i     (pixel_i),
    .tag_i       (tag),
    .cfg_i       (cfg),
    .slot_busy_o (slot_busy),
    .done_o      (done)
  );

  mbet_reorder u_rob (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (enter),
    .done_i         (done),
    .tag_o          (tag),
    .full_o         (rob_full),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ----- design/mbet_cfg_regs.sv -----
// APB register file holding origin, step, iteration limit and radius.
// Depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_cfg_regs import mbet_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output mbet_cfg_t         cfg_o
);

  mbet_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  mbet_reg_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = mbet_reg_e'(paddr[APB_AW-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ORIGIN_RE:  cfg_d.origin_re        = pwdata;
        REG_ORIGIN_IM:  cfg_d.origin_im        = pwdata;
        REG_PIXEL_STEP: cfg_d.pixel_step       = pwdata[STEP_W-1:0];
        REG_MAX_ITER:   cfg_d.max_iter         = pwdata[ITER_W-1:0];
        REG_RADIUS_SQ:  cfg_d.escape_radius_sq = pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_RE:  prdata = cfg_q.origin_re;
      REG_ORIGIN_IM:  prdata = cfg_q.origin_im;
      REG_PIXEL_STEP: prdata = 32'(cfg_q.pixel_step);
      REG_MAX_ITER:   prdata = 32'(cfg_q.max_iter);
      REG_RADIUS_SQ:  prdata = 32'(cfg_q.escape_radius_sq);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_re        <= RST_ORIGIN_RE;
      cfg_q.origin_im        <= RST_ORIGIN_IM;
      cfg_q.pixel_step       <= RST_STEP;
      cfg_q.max_iter         <= RST_MAX_ITER;
      cfg_q.escape_radius_sq <= RST_RADIUS_SQ;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/mbet_iter_ring.sv -----
// Three-stage iteration ring: multiply, add/escape test, shift/saturate.
// Depends on mbet_pkg. A fresh pixel's first pass forms c on the same multipliers.
`timescale 1ns / 1ps

module mbet_iter_ring import mbet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enter_i,
  input  mbet_in_t         pixel_i,
  input  logic [TAG_W-1:0] tag_i,
  input  mbet_cfg_t        cfg_i,
  output logic             slot_busy_o,
  output mbet_done_t       done_o
);

  // re/im hold column/row on the first pass
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic               first;
    logic [ITER_W-1:0]  n;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [63:0] p_xx;
    logic signed [63:0] p_yy;
    logic signed [63:0] p_xy;
  } st1_t;

  typedef struct packed {
    ctx_t               ctx;
    logic signed [63:0] diff;
    logic signed [63:0] xy;
  } st2_t;

  logic s1_vld_q, s2_vld_q, s3_vld_q;
  logic s1_vld_d, s2_vld_d, s3_vld_d;
  st1_t s1_q, s1_d;
  st2_t s2_q, s2_d;
  ctx_t s3_q, s3_d;

  ctx_t               head;
  logic signed [32:0] a_xx, b_xx, a_yy, b_yy, a_re, a_im;
  logic signed [65:0] m_xx, m_yy, m_xy;
  logic [63:0]        mag;
  logic               lim_hit, escaped, finish;

  // stage 1: ring entry and products
  always_comb begin
    if (s3_vld_q) begin
      head = s3_q;
    end else begin
      head       = '0;
      head.tag   = tag_i;
      head.first = 1'b1;
      head.re    = 32'(pixel_i.pixel_col);
      head.im    = 32'(pixel_i.pixel_row);
    end
    s1_vld_d = s3_vld_q | enter_i;

    a_re = {head.re[31], head.re};
    a_im = {head.im[31], head.im};
    if (head.first) begin
      a_xx = {1'b0, head.re};
      b_xx = {2'b00, cfg_i.pixel_step};
      a_yy = {1'b0, head.im};
      b_yy = {2'b00, cfg_i.pixel_step};
    end else begin
      a_xx = a_re;
      b_xx = a_re;
      a_yy = a_im;
      b_yy = a_im;
    end
    m_xx = a_xx * b_xx;
    m_yy = a_yy * b_yy;
    m_xy = a_re * a_im;

    s1_d.ctx  = head;
    s1_d.p_xx = m_xx[63:0];
    s1_d.p_yy = m_yy[63:0];
    s1_d.p_xy = m_xy[63:0];
  end

  // stage 2: sums, limit and escape test, c on first pass
  always_comb begin
    mag     = s1_q.p_xx + s1_q.p_yy;
    lim_hit = s1_q.ctx.n >= cfg_i.max_iter;
    escaped = mag[63:2*FRAC_BITS] >= MAG_W'(cfg_i.escape_radius_sq);
    finish  = !s1_q.ctx.first & (lim_hit | escaped);

    done_o.valid          = s1_vld_q & finish;
    done_o.tag            = s1_q.ctx.tag;
    done_o.res.iter_count = s1_q.ctx.n;
    done_o.res.inside_res = lim_hit;
    done_o.res.escape_re  = lim_hit ? '0 : s1_q.ctx.re;
    done_o.res.escape_im  = lim_hit ? '0 : s1_q.ctx.im;

    s2_vld_d  = s1_vld_q & !finish;
    s2_d.ctx  = s1_q.ctx;
    s2_d.diff = s1_q.p_xx - s1_q.p_yy;
    s2_d.xy   = s1_q.p_xy;
    if (s1_q.ctx.first) begin
      s2_d.ctx.c_re = sat32(64'(cfg_i.origin_re) + s1_q.p_xx);
      s2_d.ctx.c_im = sat32(64'(cfg_i.origin_im) + s1_q.p_yy);
    end
  end

  // stage 3: z update
  always_comb begin
    s3_vld_d = s2_vld_q;
    s3_d     = s2_q.ctx;
    if (s2_q.ctx.first) begin
      s3_d.first = 1'b0;
      s3_d.n     = '0;
      s3_d.re    = '0;
      s3_d.im    = '0;
    end else begin
      s3_d.n  = s2_q.ctx.n + ITER_W'(1);
      s3_d.re = sat32((s2_q.diff >>> FRAC_BITS) + 64'(s2_q.ctx.c_re));
      s3_d.im = sat32((s2_q.xy >>> (FRAC_BITS - 1)) + 64'(s2_q.ctx.c_im));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
      s2_vld_q <= s2_vld_d;
      s3_vld_q <= s3_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    s3_q <= s3_d;
  end

  assign slot_busy_o = s3_vld_q;

endmodule

// ----- design/mbet_reorder.sv -----
// Reorder buffer: hands out tags, collects finished words, retires in order.
// Depends on mbet_pkg.
`timescale 1ns / 1ps

module mbet_reorder import mbet_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  mbet_done_t       done_i,
  output logic [TAG_W-1:0] tag_o,
  output logic             full_o,
  output logic             result_valid_o,
  output mbet_out_t        result_o
);

  mbet_out_t              rob_q [ROB_DEPTH];
  logic [ROB_DEPTH-1:0]   done_q, done_d;
  logic [TAG_W-1:0]       head_q, head_d, tail_q, tail_d;
  logic [TAG_W:0]         cnt_q, cnt_d;
  logic                   retire;
  logic                   res_vld_q;
  mbet_out_t              res_q;

  assign retire = done_q[head_q];
  assign full_o = cnt_q == (TAG_W + 1)'(ROB_DEPTH);
  assign tag_o  = tail_q;

  always_comb begin
    done_d = done_q;
    if (retire) begin
      done_d[head_q] = 1'b0;
    end
    if (done_i.valid) begin
      done_d[done_i.tag] = 1'b1;
    end
    head_d = retire   ? head_q + TAG_W'(1) : head_q;
    tail_d = accept_i ? tail_q + TAG_W'(1) : tail_q;
    unique case ({accept_i, retire})
      2'b10:   cnt_d = cnt_q + (TAG_W + 1)'(1);
      2'b01:   cnt_d = cnt_q - (TAG_W + 1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cnt_q     <= cnt_d;
      res_vld_q <= retire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i.valid) begin
      rob_q[done_i.tag] <= done_i.res;
    end
    if (retire) begin
      res_q <= rob_q[head_q];
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

// ----- design/mbet_checker.sv -----
// Port-level checker for the escape-time core, bound to the top level.
// Depends on mbet_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbet_checker import mbet_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input mbet_in_t          pixel_i,
  input logic              result_valid_o,
  input mbet_out_t         result_o,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [APB_AW-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata,
  input logic              pready
);

  logic           acc;
  logic [TAG_W:0] pend_q;

  assign acc = start & !busy;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (acc && !result_valid_o) begin
      pend_q <= pend_q + (TAG_W + 1)'(1);
    end else if (!acc && result_valid_o) begin
      pend_q <= pend_q - (TAG_W + 1)'(1);
    end
  end

  `ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready, "pready dropped")
  `ASSERT_IMPLIES(a_no_spurious, clk_i, rst_ni, result_valid_o, pend_q != '0, "result without pixel")
  `ASSERT_IMPLIES(a_room, clk_i, rst_ni, acc, (pend_q < (TAG_W + 1)'(ROB_DEPTH)) || result_valid_o, "too many outstanding")
  `ASSERT_IMPLIES(a_inside_zero, clk_i, rst_ni, result_valid_o && result_o.inside_res, result_o.escape_re == '0 && result_o.escape_im == '0, "inside point with non-zero z")

endmodule

bind mandelbrot_escape_time_core mbet_checker u_mbet_checker (.*);
